// ===== rtl/core/acpt_pkg.sv =====
// Shared constants and types for the allowed-collision pair table.
// Holds the command codes, the item field layout and the result record.
// No dependencies.
`timescale 1ns / 1ps

package acpt_pkg;

  localparam int ACT_W  = 4;
  localparam int ID_W   = 6;
  localparam int CELL_W = 2;
  localparam int CELL_V = 1;
  localparam int CELL_A = 0;

  localparam int IN_A_LSB   = ACT_W;
  localparam int IN_B_LSB   = ACT_W + ID_W;
  localparam int IN_V_BIT   = ACT_W + 2 * ID_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_QUERY    = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SET_PAIR = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SET_ROWS = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SET_ALL  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_REM_PAIR = 4'd4;
  localparam logic [ACT_W-1:0] ACT_REM_OBJ  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SET_DEF  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_REM_DEF  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd8;

  // Packed so that pair_found lands in bit 0.
  typedef struct packed {
    logic first_has_default;
    logic first_has_row;
    logic resolved_allowed;
    logic resolved_found;
    logic pair_allowed;
    logic pair_found;
  } acpt_res_t;

endpackage

// ===== rtl/core/acpt_pair_mem.sv =====
// Pair mark RAM: one write port, one read port, registered read data.
// Uses acpt_pkg for the cell width.
`timescale 1ns / 1ps

module acpt_pair_mem
  import acpt_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells_r [1 << AW];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells_r[waddr] <= wdata;
    end
    rdata_r <= cells_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/acpt_obj_mem.sv =====
// Per-object RAM (default mark and row count): one write port, two read
// ports, registered read data. No package dependencies.
`timescale 1ns / 1ps

module acpt_obj_mem #(
  parameter int AW = 6,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] words_r [1 << AW];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      words_r[waddr] <= wdata;
    end
    rdata_a_r <= words_r[raddr_a];
    rdata_b_r <= words_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/core/allowed_collision_pair_table.sv =====
// Allowed-collision pair table: a symmetric allowed/never mark for every pair of object ids
// below MAX_OBJECTS (ids are 6 bits, so at most 64 objects are used) plus an optional default
// mark per object. Each command item yields one result item describing the pair after the
// command; a query with no pair mark falls back to the defaults, never winning over always.
// Pair marks live in a pair RAM of 2**(2*ceil(log2(N))) cells (4096 at 64 objects), defaults
// and row counts in a per-object RAM with two read ports; every read is registered.
// Query, unused codes and items whose checked ids are out of range only read; set or remove
// pair writes the cell, then its mirror unless both ids match; set or remove default rewrites
// the object word; set against all rows and remove object walk the objects one at a time; set
// all existing and clear sweep the pair RAM one cell a cycle, clear also zeroing object words.
// After reset the same clearing pass runs before the first item is taken.
// Depends on acpt_pkg, acpt_pair_mem and acpt_obj_mem.
`timescale 1ns / 1ps

module allowed_collision_pair_table
  import acpt_pkg::*;
#(
  parameter int MAX_OBJECTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // action[3:0], first_id[9:4], second_id[15:10], allowed[16], zero[23:17]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pair_found[0], pair_allowed[1], resolved_found[2], resolved_allowed[3],
  // first_has_row[4], first_has_default[5], zero[7:6]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NOBJ = (MAX_OBJECTS > (1 << ID_W)) ? (1 << ID_W) : MAX_OBJECTS;
  localparam int IW   = $clog2(NOBJ);
  localparam int PAW  = 2 * IW;
  localparam int CW   = $clog2(NOBJ + 1);
  localparam int OW   = CW + 2;
  localparam int ODV  = OW - 1;
  localparam int ODA  = OW - 2;
  localparam logic [ID_W:0] NOBJ_ID  = (ID_W + 1)'(NOBJ);
  localparam logic [IW-1:0] LAST_OBJ = IW'(NOBJ - 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_P_WR   = 12'b0000_0000_0010,
    ST_WR2    = 12'b0000_0000_0100,
    ST_W_RD   = 12'b0000_0000_1000,
    ST_W_WR   = 12'b0000_0001_0000,
    ST_W_END  = 12'b0000_0010_0000,
    ST_DEF    = 12'b0000_0100_0000,
    ST_SA     = 12'b0000_1000_0000,
    ST_SA_END = 12'b0001_0000_0000,
    ST_CLR    = 12'b0010_0000_0000,
    ST_QRD    = 12'b0100_0000_0000,
    ST_RES    = 12'b1000_0000_0000
  } state_t;

  function automatic logic id_ok(input logic [ID_W-1:0] id);
    return {1'b0, id} < NOBJ_ID;
  endfunction

  function automatic logic [CW-1:0] cnt_step(input logic [CW-1:0] cnt, input logic hit,
                                             input logic set);
    logic [CW-1:0] res;
    res = cnt;
    if (set && !hit) begin
      res = cnt + CW'(1);
    end else if (!set && hit) begin
      res = cnt - CW'(1);
    end
    return res;
  endfunction

  state_t            state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [PAW-1:0]    sw_r, sw_nxt;
  logic              out_valid_r, out_valid_nxt;
  acpt_res_t         out_data_r, out_data_nxt;

  logic [ACT_W-1:0]  act_r;
  logic [ID_W-1:0]   a_r, b_r;
  logic              v_r;
  logic [CW-1:0]     cnt_a_r;
  logic              hit_r;
  logic [OW-1:0]     ob_r;

  logic              in_fire;
  logic [ACT_W-1:0]  in_act;
  logic [ID_W-1:0]   in_a, in_b;
  logic              in_v;
  logic              in_a_ok, in_b_ok;
  logic [IW-1:0]     in_a_idx, in_b_idx, a_idx, b_idx, j_idx, other_idx;

  logic              pm_we;
  logic [PAW-1:0]    pm_waddr, pm_raddr;
  logic [CELL_W-1:0] pm_wdata, pm_rdata;
  logic              om_we;
  logic [IW-1:0]     om_waddr, om_raddr_a, om_raddr_b;
  logic [OW-1:0]     om_wdata, om_rdata_a, om_rdata_b;

  logic              set_mode, pair_mode, set_def;
  logic [CELL_W-1:0] new_cell, sa_cell;
  logic              pm_hit, walk_last, walk_elig;
  logic [CW-1:0]     om_a_cnt, om_b_cnt;
  acpt_res_t         res;

  assign in_act   = in_tdata[ACT_W-1:0];
  assign in_a     = in_tdata[IN_A_LSB +: ID_W];
  assign in_b     = in_tdata[IN_B_LSB +: ID_W];
  assign in_v     = in_tdata[IN_V_BIT];
  assign in_a_ok  = id_ok(in_a);
  assign in_b_ok  = id_ok(in_b);
  assign in_a_idx = in_a[IW-1:0];
  assign in_b_idx = in_b[IW-1:0];
  assign a_idx    = a_r[IW-1:0];
  assign b_idx    = b_r[IW-1:0];
  assign j_idx    = sw_r[IW-1:0];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign set_mode  = (act_r == ACT_SET_PAIR) || (act_r == ACT_SET_ROWS);
  assign pair_mode = (act_r == ACT_SET_PAIR) || (act_r == ACT_REM_PAIR);
  assign set_def   = (act_r == ACT_SET_DEF);
  assign new_cell  = {set_mode, set_mode & v_r};
  assign sa_cell   = {1'b1, v_r};
  assign pm_hit    = pm_rdata[CELL_V];
  assign om_a_cnt  = om_rdata_a[CW-1:0];
  assign om_b_cnt  = om_rdata_b[CW-1:0];
  assign walk_last = (j_idx == LAST_OBJ);
  assign other_idx = pair_mode ? b_idx : j_idx;
  // set: other rows that existed before; remove: any live cell in the row
  assign walk_elig = set_mode ? ((j_idx != a_idx) && (om_b_cnt != '0)) : pm_hit;

  acpt_pair_mem #(
    .AW(PAW)
  ) u_pair_mem (
    .clk  (clk),
    .we   (pm_we),
    .waddr(pm_waddr),
    .wdata(pm_wdata),
    .raddr(pm_raddr),
    .rdata(pm_rdata)
  );

  acpt_obj_mem #(
    .AW(IW),
    .DW(OW)
  ) u_obj_mem (
    .clk    (clk),
    .we     (om_we),
    .waddr  (om_waddr),
    .wdata  (om_wdata),
    .raddr_a(om_raddr_a),
    .raddr_b(om_raddr_b),
    .rdata_a(om_rdata_a),
    .rdata_b(om_rdata_b)
  );

  // Resolve the pair from the latest reads; out-of-range ids read as absent.
  always_comb begin
    logic a_ok, b_ok, pf, pa, dav, daa, dbv, dba;
    a_ok = id_ok(a_r);
    b_ok = id_ok(b_r);
    pf   = a_ok && b_ok && pm_rdata[CELL_V];
    pa   = pf && pm_rdata[CELL_A];
    dav  = a_ok && om_rdata_a[ODV];
    daa  = om_rdata_a[ODA];
    dbv  = b_ok && om_rdata_b[ODV];
    dba  = om_rdata_b[ODA];
    res.pair_found        = pf;
    res.pair_allowed      = pa;
    res.resolved_found    = pf | dav | dbv;
    res.resolved_allowed  = pf ? pa : ((dav | dbv) & (~dav | daa) & (~dbv | dba));
    res.first_has_row     = a_ok && (om_a_cnt != '0);
    res.first_has_default = dav;
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    sw_nxt        = sw_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    pm_we         = 1'b0;
    pm_waddr      = {a_idx, b_idx};
    pm_wdata      = new_cell;
    pm_raddr      = {a_idx, b_idx};
    om_we         = 1'b0;
    om_waddr      = a_idx;
    om_wdata      = om_rdata_a;
    om_raddr_a    = a_idx;
    om_raddr_b    = b_idx;
    case (state_r)
      ST_IDLE: begin
        pm_raddr   = {in_a_idx, in_b_idx};
        om_raddr_a = in_a_idx;
        om_raddr_b = in_b_idx;
        if (in_fire) begin
          case (in_act)
            ACT_SET_PAIR, ACT_REM_PAIR: state_nxt = (in_a_ok && in_b_ok) ? ST_P_WR : ST_RES;
            ACT_SET_ROWS, ACT_REM_OBJ:  state_nxt = in_a_ok ? ST_W_RD : ST_RES;
            ACT_SET_ALL:                state_nxt = ST_SA;
            ACT_SET_DEF, ACT_REM_DEF:   state_nxt = in_a_ok ? ST_DEF : ST_RES;
            ACT_CLEAR:                  state_nxt = ST_CLR;
            default:                    state_nxt = ST_RES;
          endcase
        end
      end
      ST_P_WR: begin
        pm_we     = 1'b1;
        om_we     = 1'b1;
        om_wdata  = {om_rdata_a[ODV:ODA], cnt_step(om_a_cnt, pm_hit, set_mode)};
        state_nxt = (a_idx != b_idx) ? ST_WR2 : ST_QRD;
      end
      ST_WR2: begin
        // mirror cell and the other object's row count
        pm_we    = 1'b1;
        pm_waddr = {other_idx, a_idx};
        om_we    = 1'b1;
        om_waddr = other_idx;
        om_wdata = {ob_r[ODV:ODA], cnt_step(ob_r[CW-1:0], hit_r, set_mode)};
        if (pair_mode) begin
          state_nxt = ST_QRD;
        end else if (walk_last) begin
          state_nxt = ST_W_END;
        end else begin
          sw_nxt    = sw_r + PAW'(1);
          state_nxt = ST_W_RD;
        end
      end
      ST_W_RD: begin
        pm_raddr   = {a_idx, j_idx};
        om_raddr_b = j_idx;
        state_nxt  = ST_W_WR;
      end
      ST_W_WR: begin
        pm_waddr = {a_idx, j_idx};
        pm_we    = walk_elig;
        if (walk_elig && (j_idx != a_idx)) begin
          state_nxt = ST_WR2;
        end else if (walk_last) begin
          state_nxt = ST_W_END;
        end else begin
          sw_nxt    = sw_r + PAW'(1);
          state_nxt = ST_W_RD;
        end
      end
      ST_W_END: begin
        om_we     = 1'b1;
        om_wdata  = {om_rdata_a[ODV:ODA], set_mode ? cnt_a_r : CW'(0)};
        sw_nxt    = '0;
        state_nxt = ST_QRD;
      end
      ST_DEF: begin
        om_we     = 1'b1;
        om_wdata  = {set_def, set_def & v_r, om_a_cnt};
        state_nxt = ST_QRD;
      end
      ST_SA: begin
        // read cell sw_r while writing back cell sw_r - 1, read before it
        pm_raddr = sw_r;
        pm_waddr = sw_r - PAW'(1);
        pm_wdata = sa_cell;
        pm_we    = (sw_r != '0) && pm_hit;
        sw_nxt   = sw_r + PAW'(1);
        if (&sw_r) begin
          state_nxt = ST_SA_END;
        end
      end
      ST_SA_END: begin
        pm_waddr  = sw_r - PAW'(1);
        pm_wdata  = sa_cell;
        pm_we     = pm_hit;
        state_nxt = ST_QRD;
      end
      ST_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = sw_r;
        pm_wdata = '0;
        om_we    = 1'b1;
        om_waddr = sw_r[IW-1:0];
        om_wdata = '0;
        sw_nxt   = sw_r + PAW'(1);
        if (&sw_r) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_QRD;
        end
      end
      ST_QRD: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      init_r      <= 1'b1;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      act_r <= in_act;
      a_r   <= in_a;
      b_r   <= in_b;
      v_r   <= in_v;
    end
    if (state_r == ST_W_RD && j_idx == '0) begin
      cnt_a_r <= om_a_cnt;
    end else if (state_r == ST_W_WR && walk_elig && set_mode && !pm_hit) begin
      cnt_a_r <= cnt_a_r + CW'(1);
    end
    // hold the old cell state and the other object's word for the mirror write
    if (state_r == ST_P_WR || state_r == ST_W_WR) begin
      hit_r <= pm_hit;
      ob_r  <= om_rdata_b;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

`ifndef SYNTHESIS
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RES |-> !out_valid_r)
    else $error("result would overwrite an item not yet taken");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("accepted item produced no work");

  a_mirror_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P_WR && a_r != b_r) |=> state_r == ST_WR2)
    else $error("pair update missed its mirror cell");

  a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> sw_r == '0)
    else $error("sweep counter not parked at zero");
`endif

endmodule

// ===== bench/allowed_collision_pair_table_tb.sv =====
// Self-checking bench for the allowed-collision pair table: a directed table of commands,
// then three phases of random commands mostly on hot ids, each result compared to a pinned
// expectation or a local predictor. Depends on acpt_pkg and allowed_collision_pair_table.
`timescale 1ns / 1ps

module allowed_collision_pair_table_tb;
  import acpt_pkg::*;

  localparam int NOBJ            = 64;
  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int ITEMS_PER_PHASE = 560;
  localparam int HOT_IDS         = 6;
  localparam int DRAIN_CYCLES    = 200;
  localparam int MAX_REPORTS     = 10;
  // Sweeps of the whole pair RAM dominate the run time.
  localparam int RUN_LIMIT_NS    = 10_000_000;

  // Codes the block leaves unused; they behave as a query.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd9;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  first;
    logic [ID_W-1:0]  second;
    logic             mark;
    logic             pinned;
    acpt_res_t        res;   // {has_default, has_row, res_allowed, res_found, allowed, found}
  } step_t;

  localparam int DIRECTED_ROWS = 23;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{ACT_QUERY,    6'd0,  6'd0,  1'b0, 1'b1, 6'b000000},
    '{ACT_QUERY,    6'd63, 6'd63, 1'b1, 1'b1, 6'b000000},
    '{ACT_SET_DEF,  6'd63, 6'd63, 1'b0, 1'b1, 6'b100100},
    '{ACT_SET_PAIR, 6'd0,  6'd63, 1'b1, 1'b1, 6'b011111},
    '{ACT_QUERY,    6'd63, 6'd0,  1'b0, 1'b1, 6'b111111},
    '{ACT_SET_PAIR, 6'd5,  6'd5,  1'b0, 1'b0, 6'b000000},
    '{ACT_QUERY,    6'd5,  6'd5,  1'b1, 1'b0, 6'b000000},
    '{ACT_REM_PAIR, 6'd5,  6'd5,  1'b1, 1'b0, 6'b000000},
    '{ACT_SET_DEF,  6'd0,  6'd10, 1'b1, 1'b0, 6'b000000},
    '{ACT_QUERY,    6'd0,  6'd10, 1'b0, 1'b0, 6'b000000},
    '{ACT_SET_DEF,  6'd10, 6'd0,  1'b0, 1'b0, 6'b000000},
    '{ACT_QUERY,    6'd0,  6'd10, 1'b1, 1'b0, 6'b000000},
    '{ACT_SET_ROWS, 6'd10, 6'd0,  1'b1, 1'b0, 6'b000000},
    '{ACT_QUERY,    6'd63, 6'd10, 1'b0, 1'b0, 6'b000000},
    '{ACT_SET_ALL,  6'd0,  6'd10, 1'b0, 1'b0, 6'b000000},
    '{ACT_REM_OBJ,  6'd63, 6'd0,  1'b1, 1'b0, 6'b000000},
    '{ACT_REM_DEF,  6'd0,  6'd10, 1'b0, 1'b0, 6'b000000},
    '{ACT_REM_PAIR, 6'd0,  6'd10, 1'b1, 1'b0, 6'b000000},
    '{ACT_SPARE_LO, 6'd63, 6'd63, 1'b1, 1'b0, 6'b000000},
    '{ACT_SPARE_HI, 6'd0,  6'd0,  1'b1, 1'b0, 6'b000000},
    '{ACT_CLEAR,    6'd63, 6'd0,  1'b1, 1'b1, 6'b000000},
    '{ACT_SET_ROWS, 6'd63, 6'd0,  1'b1, 1'b1, 6'b000000},
    '{ACT_QUERY,    6'd63, 6'd63, 1'b0, 1'b1, 6'b000000}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Typed expectation that travels with the item currently offered.
  logic      pinned_valid = 1'b0;
  acpt_res_t pinned_res = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  logic [ID_W-1:0] hot_ids [HOT_IDS];

  // Predictor state.
  logic [CELL_W-1:0] pair_mark [NOBJ*NOBJ];
  logic [CELL_W-1:0] default_mark [NOBJ];
  int                row_fill [NOBJ];

  acpt_res_t pending_results [$];
  acpt_res_t model_res;
  acpt_res_t seen_res;
  acpt_res_t want_res;

  allowed_collision_pair_table #(
    .MAX_OBJECTS(NOBJ)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void clear_model();
    for (int k = 0; k < NOBJ * NOBJ; k++) pair_mark[k] = '0;
    for (int k = 0; k < NOBJ; k++) begin
      default_mark[k] = '0;
      row_fill[k] = 0;
    end
  endfunction

  function automatic void put_cell(int r, int c, logic v);
    if (!pair_mark[r*NOBJ+c][CELL_V]) row_fill[r]++;
    pair_mark[r*NOBJ+c] = {1'b1, v};
  endfunction

  function automatic void drop_cell(int r, int c);
    if (pair_mark[r*NOBJ+c][CELL_V]) begin
      pair_mark[r*NOBJ+c] = '0;
      row_fill[r]--;
    end
  endfunction

  function automatic void put_pair(int r, int c, logic v);
    put_cell(r, c, v);
    if (r != c) put_cell(c, r, v);
  endfunction

  // Apply one command to the shadow table and return the pair view afterwards.
  function automatic acpt_res_t apply_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] a,
                                              logic [ID_W-1:0] b, logic v);
    acpt_res_t r;
    logic [CELL_W-1:0] pm;
    logic [CELL_W-1:0] da;
    logic [CELL_W-1:0] db;
    logic a_ok;
    logic b_ok;
    logic x;
    logic y;
    a_ok = int'(a) < NOBJ;
    b_ok = int'(b) < NOBJ;
    case (act)
      ACT_SET_PAIR: if (a_ok && b_ok) put_pair(a, b, v);
      ACT_SET_ROWS: begin
        if (a_ok) begin
          // Rows touched earlier in the walk are never visited again.
          for (int j = 0; j < NOBJ; j++)
            if (j != int'(a) && row_fill[j] != 0) put_pair(a, j, v);
        end
      end
      ACT_SET_ALL: begin
        for (int k = 0; k < NOBJ * NOBJ; k++)
          if (pair_mark[k][CELL_V]) pair_mark[k] = {1'b1, v};
      end
      ACT_REM_PAIR: begin
        if (a_ok && b_ok) begin
          drop_cell(a, b);
          if (a != b) drop_cell(b, a);
        end
      end
      ACT_REM_OBJ: begin
        if (a_ok)
          for (int j = 0; j < NOBJ; j++) begin
            drop_cell(a, j);
            drop_cell(j, a);
          end
      end
      ACT_SET_DEF: if (a_ok) default_mark[a] = {1'b1, v};
      ACT_REM_DEF: if (a_ok) default_mark[a] = '0;
      ACT_CLEAR:   clear_model();
      default: ;
    endcase

    pm = '0;
    da = '0;
    db = '0;
    if (a_ok && b_ok) pm = pair_mark[int'(a)*NOBJ+int'(b)];
    if (a_ok) da = default_mark[a];
    if (b_ok) db = default_mark[b];

    r = '0;
    r.pair_found   = pm[CELL_V];
    r.pair_allowed = pm[CELL_V] & pm[CELL_A];
    if (pm[CELL_V]) begin
      r.resolved_found   = 1'b1;
      r.resolved_allowed = pm[CELL_A];
    end else if (da[CELL_V] || db[CELL_V]) begin
      // An absent default does not veto; a present never does.
      x = da[CELL_V] ? da[CELL_A] : 1'b1;
      y = db[CELL_V] ? db[CELL_A] : 1'b1;
      r.resolved_found   = 1'b1;
      r.resolved_allowed = x & y;
    end
    r.first_has_row     = a_ok && row_fill[a] != 0;
    r.first_has_default = da[CELL_V];
    return r;
  endfunction

  function automatic string show_result(acpt_res_t r);
    return $sformatf("found=%0d allowed=%0d res_found=%0d res_allowed=%0d row=%0d def=%0d",
                     r.pair_found, r.pair_allowed, r.resolved_found, r.resolved_allowed,
                     r.first_has_row, r.first_has_default);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return hot_ids[$urandom_range(0, HOT_IDS - 1)];
    if (roll < 90) return ID_W'($urandom_range(0, NOBJ - 1));
    return (roll < 95) ? '0 : ID_W'(NOBJ - 1);
  endfunction

  // Keep the full-table sweeps rare; each one walks the whole pair RAM.
  function automatic logic [ACT_W-1:0] pick_action();
    int roll;
    roll = $urandom_range(0, 199);
    if (roll < 50)  return ACT_QUERY;
    if (roll < 100) return ACT_SET_PAIR;
    if (roll < 112) return ACT_SET_ROWS;
    if (roll < 114) return ACT_SET_ALL;
    if (roll < 138) return ACT_REM_PAIR;
    if (roll < 146) return ACT_REM_OBJ;
    if (roll < 170) return ACT_SET_DEF;
    if (roll < 182) return ACT_REM_DEF;
    if (roll < 184) return ACT_CLEAR;
    return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input logic v,
                           input logic pin, input acpt_res_t pin_res);
    logic [IN_TDATA_W-1:0] td;
    td = '0;
    td[ACT_W-1:0]         = act;
    td[IN_A_LSB +: ID_W]  = a;
    td[IN_B_LSB +: ID_W]  = b;
    td[IN_V_BIT]          = v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= td;
    pinned_valid <= pin;
    pinned_res   <= pin_res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict on every accepted command, check every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        model_res = apply_command(in_tdata[ACT_W-1:0], in_tdata[IN_A_LSB +: ID_W],
                                  in_tdata[IN_B_LSB +: ID_W], in_tdata[IN_V_BIT]);
        pending_results.insert(pending_results.size(), pinned_valid ? pinned_res : model_res);
      end
      if (out_tvalid && out_tready) begin
        seen_res = acpt_res_t'(out_tdata[$bits(acpt_res_t)-1:0]);
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result item: %s", show_result(seen_res));
        end else begin
          want_res = pending_results.pop_front();
          if (seen_res.pair_found !== want_res.pair_found ||
              seen_res.pair_allowed !== want_res.pair_allowed ||
              seen_res.resolved_found !== want_res.resolved_found ||
              seen_res.resolved_allowed !== want_res.resolved_allowed ||
              seen_res.first_has_row !== want_res.first_has_row ||
              seen_res.first_has_default !== want_res.first_has_default) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("result mismatch at %0t: expected %s, got %s", $realtime,
                       show_result(want_res), show_result(seen_res));
          end
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clear_model();
    send_idle_pct = 14;
    recv_idle_pct <= 46;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_ROWS; k++)
      send_item(DIRECTED[k].act, DIRECTED[k].first, DIRECTED[k].second, DIRECTED[k].mark,
                DIRECTED[k].pinned, DIRECTED[k].res);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct <= 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct <= 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      // Draw a fresh small id pool so pairs collide and rows fill up.
      for (int h = 0; h < HOT_IDS; h++) hot_ids[h] = ID_W'($urandom_range(0, NOBJ - 1));
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_item(pick_action(), pick_id(), pick_id(), 1'($urandom_range(0, 1)),
                  1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== allowed_collision_pair_table.f =====
rtl/core/acpt_pkg.sv
rtl/core/acpt_pair_mem.sv
rtl/core/acpt_obj_mem.sv
rtl/core/allowed_collision_pair_table.sv
bench/allowed_collision_pair_table_tb.sv
